FILE: design/bbcm_pkg.sv
// Shared types and constants of the clipped-window box blur.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package bbcm_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int MAX_RADIUS = 15;
    localparam int RING_ROWS  = 2 * MAX_RADIUS + 2;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(RING_ROWS);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int DIM_W  = 13;
    localparam int POS_W  = 25;
    localparam int SUM_W  = 26;
    localparam int NUM_W  = 26;
    localparam int CNT_W  = 10;
    localparam int LAG_W  = 17;

    // configuration register indexes
    localparam logic [1:0] CFG_RADIUS = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;
    localparam logic [1:0] CFG_DEEP   = 2'd3;

    // request codes
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    typedef logic [63:0] t_pixel;

    typedef struct packed {
        logic        req_type;
        logic [15:0] in_blue;
        logic [15:0] in_green;
        logic [15:0] in_red;
        logic [15:0] in_alpha;
    } t_in_word;

    typedef struct packed {
        logic [15:0] out_blue;
        logic [15:0] out_green;
        logic [15:0] out_red;
        logic [15:0] out_alpha;
        logic        frame_end;
        logic        skipped;
    } t_out_word;

endpackage

`default_nettype wire

FILE: design/box_blur_clipped_mean.sv
// Top level of the clipped-window box blur: sequencer, window sums, output word.
// Depends on bbcm_pkg, bbcm_div and bbcm_store.
//
// Use: pixel words enter on i_in_valid/o_in_ready in raster order; req_type
// set marks a flush word that drains one pending result, if there is one.
// Results leave on o_out_valid/i_out_ready, lagging the input by
// radius rows plus radius pixels; frame_end tags the frame's last result.
// Configuration is written on i_cfg_we with i_cfg_index/i_cfg_data while idle.
// One word is processed at a time: decode (accept, frame size, size products,
// position check, decode), the position divider for a stored pixel and again
// for the result position, then a setup step, a read per window pixel from the
// store's read port (up to 961), a drain step, the four parallel mean dividers
// and an output step, which a skipped result reaches straight from setup. A
// pixel word with a result runs all of these, a flush with a result all but the
// first divide, a pixel without one decode and that divide only, and a flush
// with nothing pending decode alone. Reset clears positions and loads register
// defaults; the row store is not cleared. A finished result waits in the output
// register while the next word is accepted; the sequencer stalls only when a
// new result meets a still-full output register.
`default_nettype none

module box_blur_clipped_mean (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire bbcm_pkg::t_in_word    i_in_word,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output bbcm_pkg::t_out_word        o_out_word,
    input  wire logic                  i_cfg_we,
    input  wire logic [1:0]            i_cfg_index,
    input  wire logic [12:0]           i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_CFG, S_MUL, S_CHK, S_DEC,
        S_PIN_GO, S_PIN_WAIT, S_POUT_GO, S_POUT_WAIT,
        S_WIN, S_SUM, S_DRAIN, S_CGO, S_CWAIT, S_OUT
    } t_state;

    localparam int PW = bbcm_pkg::POS_W;
    localparam int DW = bbcm_pkg::DIM_W;
    localparam int SW = bbcm_pkg::SUM_W;

    t_state               r_state;
    logic [3:0]           r_radius;
    logic [DW-1:0]        r_frame_width;
    logic [DW-1:0]        r_frame_height;
    logic                 r_deep;

    bbcm_pkg::t_in_word   r_in;
    logic [DW-1:0]        r_w;
    logic [DW-1:0]        r_h;
    logic [PW-1:0]        r_total;
    logic [bbcm_pkg::LAG_W-1:0] r_lag;
    logic [PW-1:0]        r_in_pos;
    logic [PW-1:0]        r_out_pos;
    logic [DW-1:0]        r_x;
    logic [DW-1:0]        r_y;
    logic [DW-1:0]        r_x0;
    logic [DW-1:0]        r_x1;
    logic [DW-1:0]        r_y1;
    logic [DW-1:0]        r_cx;
    logic [DW-1:0]        r_cy;
    logic [bbcm_pkg::CNT_W-1:0] r_count;
    logic [SW-1:0]        r_sum [4];
    logic                 r_rd_v;
    logic                 r_skip;
    logic                 r_fend;
    logic                 r_out_valid;
    bbcm_pkg::t_out_word  r_out_word;

    logic [DW-1:0]        eff_w;
    logic [DW-1:0]        eff_h;
    logic [DW-1:0]        rad;
    logic [DW-1:0]        win_x0;
    logic [DW-1:0]        win_y0;
    logic [DW-1:0]        win_x1;
    logic [DW-1:0]        win_y1;
    logic [4:0]           win_dx;
    logic [4:0]           win_dy;
    logic [PW:0]          in_next;
    logic [PW:0]          emit_lim;

    logic                 pdiv_start;
    logic [bbcm_pkg::NUM_W-1:0] pdiv_num;
    logic                 pdiv_done;
    logic [bbcm_pkg::NUM_W-1:0] pdiv_quot;
    logic [DW-1:0]        pdiv_rem;

    logic                 cdiv_start;
    logic [3:0]           cdiv_done;
    logic [bbcm_pkg::NUM_W-1:0] cdiv_quot [4];
    logic [DW-1:0]        cdiv_rem [4];

    logic                 st_wr_en;
    logic [bbcm_pkg::ADDR_W-1:0] st_wr_addr;
    bbcm_pkg::t_pixel     st_wr_data;
    logic                 st_rd_en;
    logic [bbcm_pkg::ADDR_W-1:0] st_rd_addr;
    bbcm_pkg::t_pixel     st_rd_data;
    logic [15:0]          lane [4];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius       <= 4'd3;
            r_frame_width  <= 13'd640;
            r_frame_height <= 13'd480;
            r_deep         <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bbcm_pkg::CFG_RADIUS: r_radius       <= i_cfg_data[3:0];
                bbcm_pkg::CFG_WIDTH:  r_frame_width  <= i_cfg_data;
                bbcm_pkg::CFG_HEIGHT: r_frame_height <= i_cfg_data;
                bbcm_pkg::CFG_DEEP:   r_deep         <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective frame size and window bounds
    always_comb begin
        eff_w = (r_frame_width == '0) ? DW'(1) :
                (r_frame_width > DW'(bbcm_pkg::MAX_WIDTH)) ? DW'(bbcm_pkg::MAX_WIDTH) :
                r_frame_width;
        eff_h = (r_frame_height == '0) ? DW'(1) :
                (r_frame_height > DW'(bbcm_pkg::MAX_HEIGHT)) ? DW'(bbcm_pkg::MAX_HEIGHT) :
                r_frame_height;
        rad    = DW'(r_radius);
        win_x0 = (r_x >= rad) ? r_x - rad : '0;
        win_y0 = (r_y >= rad) ? r_y - rad : '0;
        win_x1 = (r_x + rad >= r_w) ? r_w - 1'b1 : r_x + rad;
        win_y1 = (r_y + rad >= r_h) ? r_h - 1'b1 : r_y + rad;
        win_dx = 5'(win_x1 - win_x0);
        win_dy = 5'(win_y1 - win_y0);
        in_next  = {1'b0, r_in_pos} + 1'b1;
        emit_lim = {1'b0, r_out_pos} + (PW+1)'(r_lag);
    end

    // position divider: pixel index into row and column
    assign pdiv_start = (r_state == S_PIN_GO) || (r_state == S_POUT_GO);
    assign pdiv_num   = (r_state == S_PIN_GO) ? bbcm_pkg::NUM_W'(r_in_pos)
                                              : bbcm_pkg::NUM_W'(r_out_pos);

    bbcm_div u_pdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (pdiv_start),
        .i_num   (pdiv_num),
        .i_den   (r_w),
        .o_done  (pdiv_done),
        .o_quot  (pdiv_quot),
        .o_rem   (pdiv_rem)
    );

    // mean dividers, one per channel
    assign cdiv_start = (r_state == S_CGO);

    for (genvar c = 0; c < 4; c++) begin : g_cdiv
        bbcm_div u_cdiv (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (cdiv_start),
            .i_num   (r_sum[c]),
            .i_den   (DW'(r_count)),
            .o_done  (cdiv_done[c]),
            .o_quot  (cdiv_quot[c]),
            .o_rem   (cdiv_rem[c])
        );
    end

    // row store ports
    always_comb begin
        st_wr_en   = (r_state == S_PIN_WAIT) && pdiv_done;
        st_wr_addr = {pdiv_quot[bbcm_pkg::ROW_W-1:0], pdiv_rem[bbcm_pkg::COL_W-1:0]};
        st_wr_data = r_deep ? {r_in.in_blue, r_in.in_green, r_in.in_red, r_in.in_alpha}
                            : {8'd0, r_in.in_blue[7:0], 8'd0, r_in.in_green[7:0],
                               8'd0, r_in.in_red[7:0], 8'd0, r_in.in_alpha[7:0]};
        st_rd_en   = (r_state == S_SUM);
        st_rd_addr = {r_cy[bbcm_pkg::ROW_W-1:0], r_cx[bbcm_pkg::COL_W-1:0]};
        lane[0] = st_rd_data[63:48];
        lane[1] = st_rd_data[47:32];
        lane[2] = st_rd_data[31:16];
        lane[3] = st_rd_data[15:0];
    end

    bbcm_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (st_wr_en),
        .i_wr_addr (st_wr_addr),
        .i_wr_data (st_wr_data),
        .i_rd_en   (st_rd_en),
        .i_rd_addr (st_rd_addr),
        .o_rd_data (st_rd_data)
    );

    // window accumulation, one stored pixel per cycle
    always_ff @(posedge i_clk) begin
        r_rd_v <= (r_state == S_SUM);
        if (r_state == S_WIN) begin
            for (int c = 0; c < 4; c++) r_sum[c] <= '0;
        end else if (r_rd_v) begin
            for (int c = 0; c < 4; c++) r_sum[c] <= r_sum[c] + SW'(lane[c]);
        end
    end

    // sequencer and output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_pos    <= '0;
            r_out_pos   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a result handed over frees the output register unless a new one lands
            if (r_out_valid && i_out_ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in    <= i_in_word;
                        r_state <= S_CFG;
                    end
                end
                S_CFG: begin
                    r_w     <= eff_w;
                    r_h     <= eff_h;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_total <= PW'(r_w) * PW'(r_h);
                    r_lag   <= bbcm_pkg::LAG_W'(r_radius) * bbcm_pkg::LAG_W'(r_w)
                               + bbcm_pkg::LAG_W'(r_radius);
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    // frame size changed under the positions: restart the frame
                    if (r_out_pos >= r_total || r_in_pos > r_total) begin
                        r_in_pos  <= '0;
                        r_out_pos <= '0;
                    end
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    if (r_in.req_type == bbcm_pkg::REQ_PIXEL && r_in_pos < r_total) begin
                        r_state <= S_PIN_GO;
                    end else if (r_out_pos < r_in_pos) begin
                        r_state <= S_POUT_GO;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_PIN_GO: r_state <= S_PIN_WAIT;
                S_PIN_WAIT: begin
                    if (pdiv_done) begin
                        r_in_pos <= in_next[PW-1:0];
                        r_state  <= (emit_lim < in_next) ? S_POUT_GO : S_IDLE;
                    end
                end
                S_POUT_GO: r_state <= S_POUT_WAIT;
                S_POUT_WAIT: begin
                    if (pdiv_done) begin
                        r_x     <= pdiv_rem;
                        r_y     <= DW'(pdiv_quot);
                        r_state <= S_WIN;
                    end
                end
                S_WIN: begin
                    r_fend  <= (r_out_pos == r_total - 1'b1);
                    r_skip  <= (r_radius != '0) && ({1'b0, r_w} <= {rad, 1'b1});
                    r_x0    <= win_x0;
                    r_x1    <= win_x1;
                    r_y1    <= win_y1;
                    r_cx    <= win_x0;
                    r_cy    <= win_y0;
                    r_count <= ({5'd0, win_dx} + 10'd1) * ({5'd0, win_dy} + 10'd1);
                    if ((r_radius != '0) && ({1'b0, r_w} <= {rad, 1'b1})) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (r_cx == r_x1) begin
                        r_cx <= r_x0;
                        if (r_cy == r_y1) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_cy <= r_cy + 1'b1;
                        end
                    end else begin
                        r_cx <= r_cx + 1'b1;
                    end
                end
                S_DRAIN: r_state <= S_CGO;
                S_CGO:   r_state <= S_CWAIT;
                S_CWAIT: begin
                    if (cdiv_done[0]) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid          <= 1'b1;
                        r_out_word.out_blue  <= r_skip ? '0 : cdiv_quot[0][15:0];
                        r_out_word.out_green <= r_skip ? '0 : cdiv_quot[1][15:0];
                        r_out_word.out_red   <= r_skip ? '0 : cdiv_quot[2][15:0];
                        r_out_word.out_alpha <= r_skip ? '0 : cdiv_quot[3][15:0];
                        r_out_word.frame_end <= r_fend;
                        r_out_word.skipped   <= r_skip;
                        if (r_fend || (r_out_pos + 1'b1 >= r_total)) begin
                            r_in_pos  <= '0;
                            r_out_pos <= '0;
                        end else begin
                            r_out_pos <= r_out_pos + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // results never run ahead of the pixels taken in
    a_pos_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_pos <= r_in_pos)
        else $error("output position passed input position");

    // a skipped result carries zero blue and alpha channels and the skipped flag
    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_skip && (!r_out_valid || i_out_ready)) |=>
        (o_out_word.out_blue == '0 && o_out_word.out_alpha == '0 && o_out_word.skipped))
        else $error("skipped result with nonzero channels");

    // the mean divisor is never zero
    a_count_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CWAIT) |-> (r_count != '0))
        else $error("window count is zero");

    // the store is written only after a position divide completes
    a_wr_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_wr_en |=> (r_state != S_PIN_WAIT))
        else $error("row store written twice for one pixel");

endmodule

`default_nettype wire

FILE: design/bbcm_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on bbcm_pkg for operand widths.
`default_nettype none

module bbcm_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [bbcm_pkg::NUM_W-1:0]    i_num,
    input  wire logic [bbcm_pkg::DIM_W-1:0]    i_den,
    output logic                               o_done,
    output logic [bbcm_pkg::NUM_W-1:0]         o_quot,
    output logic [bbcm_pkg::DIM_W-1:0]         o_rem
);

    localparam int CW = $clog2(bbcm_pkg::NUM_W);

    logic                          r_busy;
    logic                          r_done;
    logic [CW-1:0]                 r_cnt;
    logic [bbcm_pkg::NUM_W-1:0]    r_q;
    logic [bbcm_pkg::DIM_W-1:0]    r_rem;
    logic [bbcm_pkg::DIM_W-1:0]    r_den;
    logic [bbcm_pkg::DIM_W:0]      trial;
    logic [bbcm_pkg::DIM_W:0]      diff;

    // shift in the next numerator bit and try to subtract
    always_comb begin
        trial = {r_rem, r_q[bbcm_pkg::NUM_W-1]};
        diff  = trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(bbcm_pkg::NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_den}) begin
                r_rem <= diff[bbcm_pkg::DIM_W-1:0];
                r_q   <= {r_q[bbcm_pkg::NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= trial[bbcm_pkg::DIM_W-1:0];
                r_q   <= {r_q[bbcm_pkg::NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

FILE: design/bbcm_store.sv
// Ring of recent pixel rows: one write port, one read port, registered read.
// Depends on bbcm_pkg for address width and the pixel type.
`default_nettype none

module bbcm_store (
    input  wire logic                          i_clk,
    input  wire logic                          i_wr_en,
    input  wire logic [bbcm_pkg::ADDR_W-1:0]   i_wr_addr,
    input  wire bbcm_pkg::t_pixel              i_wr_data,
    input  wire logic                          i_rd_en,
    input  wire logic [bbcm_pkg::ADDR_W-1:0]   i_rd_addr,
    output bbcm_pkg::t_pixel                   o_rd_data
);

    bbcm_pkg::t_pixel r_mem [2**bbcm_pkg::ADDR_W];
    bbcm_pkg::t_pixel r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: tb/blur_checker.sv
// Checker for the clipped-window box blur: watches the config port and both word channels,
// predicts each result word and compares it with what the block delivers.
// Depends on bbcm_pkg for the word types and register indexes.
`timescale 1ns / 100ps

module blur_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  bbcm_pkg::t_in_word   i_in_word,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  bbcm_pkg::t_out_word  i_out_word,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [12:0]          i_cfg_data,
    output int                   o_errors,
    output int                   o_pending
);

    // predictor copy of the registers, positions and pixel store
    logic [3:0]  radius_q;
    logic [12:0] width_q;
    logic [12:0] height_q;
    logic        deep_q;
    int unsigned in_pos;
    int unsigned out_pos;
    logic [63:0] pix_mem [int];     // {blue, green, red, alpha}, keyed row*MAX_WIDTH+col
    bbcm_pkg::t_out_word blurred_q[$];
    int          errors = 0;

    assign o_errors  = errors;
    assign o_pending = blurred_q.size();

    function automatic int unsigned eff_dim(logic [12:0] v, int unsigned lim);
        if (v == 0) return 1;
        return (v > lim) ? lim : v;
    endfunction

    // truncated window mean for one output position
    function automatic bbcm_pkg::t_out_word blur_at(int unsigned pos, int unsigned w,
                                                    int unsigned h, int unsigned r);
        int unsigned x, y, x0, y0, x1, y1, cnt, yy, xx;
        int unsigned sum [4];
        logic [63:0] px;
        bbcm_pkg::t_out_word res;
        x = pos % w;
        y = pos / w;
        res = '0;
        if (r >= 1 && w <= 2 * r + 1) begin
            res.skipped = 1'b1;
        end else begin
            x0 = (x >= r) ? x - r : 0;
            y0 = (y >= r) ? y - r : 0;
            x1 = (x + r >= w) ? w - 1 : x + r;
            y1 = (y + r >= h) ? h - 1 : y + r;
            cnt = (x1 - x0 + 1) * (y1 - y0 + 1);
            sum = '{0, 0, 0, 0};
            for (yy = y0; yy <= y1; yy++) begin
                for (xx = x0; xx <= x1; xx++) begin
                    px = pix_mem.exists((yy % bbcm_pkg::RING_ROWS) * bbcm_pkg::MAX_WIDTH + xx)
                       ? pix_mem[(yy % bbcm_pkg::RING_ROWS) * bbcm_pkg::MAX_WIDTH + xx] : '0;
                    sum[0] += px[63:48];
                    sum[1] += px[47:32];
                    sum[2] += px[31:16];
                    sum[3] += px[15:0];
                end
            end
            res.out_blue  = 16'(sum[0] / cnt);
            res.out_green = 16'(sum[1] / cnt);
            res.out_red   = 16'(sum[2] / cnt);
            res.out_alpha = 16'(sum[3] / cnt);
        end
        res.frame_end = (pos == w * h - 1);
        return res;
    endfunction

    // one accepted input word: store the pixel, maybe predict a result
    task automatic take_word(bbcm_pkg::t_in_word wd);
        int unsigned w, h, r, total, lag, row, col;
        logic [15:0] mask;
        bit emit;
        w = eff_dim(width_q, bbcm_pkg::MAX_WIDTH);
        h = eff_dim(height_q, bbcm_pkg::MAX_HEIGHT);
        r = radius_q;
        total = w * h;
        lag = r * w + r;
        if (out_pos >= total || in_pos > total) begin
            in_pos = 0;
            out_pos = 0;
        end
        if (wd.req_type == bbcm_pkg::REQ_PIXEL && in_pos < total) begin
            mask = deep_q ? 16'hFFFF : 16'h00FF;
            row = (in_pos / w) % bbcm_pkg::RING_ROWS;
            col = in_pos % w;
            pix_mem[row * bbcm_pkg::MAX_WIDTH + col] = {wd.in_blue & mask, wd.in_green & mask,
                                                         wd.in_red & mask, wd.in_alpha & mask};
            in_pos++;
            emit = (out_pos + lag < in_pos);
        end else begin
            emit = (out_pos < in_pos);
        end
        if (emit) begin
            blurred_q.push_back(blur_at(out_pos, w, h, r));
            out_pos++;
            if (out_pos >= total) begin
                in_pos = 0;
                out_pos = 0;
            end
        end
    endtask

    task automatic compare_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    // register writes, input words, result words
    always @(posedge i_clk) begin
        bbcm_pkg::t_out_word exp_w;
        if (!i_rst_n) begin
            radius_q <= 4'd3;
            width_q  <= 13'd640;
            height_q <= 13'd480;
            deep_q   <= 1'b0;
            in_pos   = 0;
            out_pos  = 0;
            blurred_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    bbcm_pkg::CFG_RADIUS: radius_q <= i_cfg_data[3:0];
                    bbcm_pkg::CFG_WIDTH:  width_q  <= i_cfg_data;
                    bbcm_pkg::CFG_HEIGHT: height_q <= i_cfg_data;
                    bbcm_pkg::CFG_DEEP:   deep_q   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                take_word(i_in_word);
            if (i_out_valid && i_out_ready) begin
                if (blurred_q.size() == 0) begin
                    $error("result word with no expectation pending");
                    errors++;
                end else begin
                    exp_w = blurred_q.pop_front();
                    compare_field("out_blue", exp_w.out_blue, i_out_word.out_blue);
                    compare_field("out_green", exp_w.out_green, i_out_word.out_green);
                    compare_field("out_red", exp_w.out_red, i_out_word.out_red);
                    compare_field("out_alpha", exp_w.out_alpha, i_out_word.out_alpha);
                    compare_field("frame_end", exp_w.frame_end, i_out_word.frame_end);
                    compare_field("skipped", exp_w.skipped, i_out_word.skipped);
                end
            end
        end
    end

endmodule

FILE: tb/testbench.sv
// Top of the box blur testbench: clock, reset, frame stimulus with random idling,
// and the verdict. Depends on bbcm_pkg, box_blur_clipped_mean and blur_checker.
`timescale 1ns / 100ps

module testbench;

    localparam int ITEM_TARGET = 1900;
    localparam int QUIET_AFTER = 1700;
    localparam int HOLD_AT     = 600;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    bbcm_pkg::t_in_word i_in_word = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    bbcm_pkg::t_out_word o_out_word;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = bbcm_pkg::CFG_RADIUS;
    logic [12:0] i_cfg_data = '0;

    int errors;
    int pending;

    // stimulus-side view of the configuration and frame positions
    logic [3:0]  cfg_r = 4'd3;
    logic [12:0] cfg_w = 13'd640;
    logic [12:0] cfg_h = 13'd480;
    int unsigned pos_in = 0;
    int unsigned pos_out = 0;
    int unsigned done_w = 0;
    int unsigned done_h = 0;
    int words_sent = 0;
    bit quiet = 1'b0;
    bit calm = 1'b0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;

    box_blur_clipped_mean DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_word(o_out_word),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    blur_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_in_word(i_in_word),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready), .i_out_word(o_out_word),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #50_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // receiver: random stall bursts, one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            i_out_ready <= 1'b0;
            repeat (2000) @(posedge i_clk);
        end else if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
            i_out_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic int unsigned eff_dim(logic [12:0] v, int unsigned lim);
        if (v == 0) return 1;
        return (v > lim) ? lim : v;
    endfunction

    // follows frame positions so the drain knows when the frame is out
    task automatic track_word(input bit is_flush, output bit wrapped);
        int unsigned w, h, total, lag;
        bit emit;
        w = eff_dim(cfg_w, bbcm_pkg::MAX_WIDTH);
        h = eff_dim(cfg_h, bbcm_pkg::MAX_HEIGHT);
        total = w * h;
        lag = cfg_r * w + cfg_r;
        wrapped = 1'b0;
        if (pos_out >= total || pos_in > total) begin
            pos_in = 0;
            pos_out = 0;
        end
        if (!is_flush && pos_in < total) begin
            pos_in++;
            emit = (pos_out + lag < pos_in);
        end else begin
            emit = (pos_out < pos_in);
        end
        if (emit) begin
            pos_out++;
            if (pos_out >= total) begin
                pos_in = 0;
                pos_out = 0;
                wrapped = 1'b1;
            end
        end
    endtask

    // offer one word; returns at the edge it is accepted, valid left high
    task automatic send_word(input bbcm_pkg::t_in_word wd, output bit wrapped);
        if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= wd;
        do @(negedge i_clk); while (!o_in_ready);
        @(posedge i_clk);
        track_word(wd.req_type == bbcm_pkg::REQ_FLUSH, wrapped);
        words_sent++;
    endtask

    function automatic bbcm_pkg::t_in_word make_word(bit flush, bit extreme);
        bbcm_pkg::t_in_word wd;
        wd.req_type = flush ? bbcm_pkg::REQ_FLUSH : bbcm_pkg::REQ_PIXEL;
        wd.in_blue  = extreme ? {16{1'($urandom_range(0, 1))}} : 16'($urandom_range(0, 65535));
        wd.in_green = extreme ? {16{1'($urandom_range(0, 1))}} : 16'($urandom_range(0, 65535));
        wd.in_red   = extreme ? {16{1'($urandom_range(0, 1))}} : 16'($urandom_range(0, 65535));
        wd.in_alpha = extreme ? {16{1'($urandom_range(0, 1))}} : 16'($urandom_range(0, 65535));
        return wd;
    endfunction

    // sender pauses until every result is out, then the block settles
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic program_block(logic [3:0] r, logic [12:0] w, logic [12:0] h, bit deep);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_index <= bbcm_pkg::CFG_RADIUS;
        i_cfg_data <= 13'(r);
        @(posedge i_clk);
        i_cfg_index <= bbcm_pkg::CFG_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        i_cfg_index <= bbcm_pkg::CFG_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        i_cfg_index <= bbcm_pkg::CFG_DEEP;
        i_cfg_data <= 13'(deep);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_r = r;
        cfg_w = w;
        cfg_h = h;
    endtask

    // one frame of pixels, then flushes (now and then a dropped pixel) until it drains
    task automatic run_frame(bit extreme);
        int unsigned w, h, i;
        bit wrapped, finished, early_ok;
        w = eff_dim(cfg_w, bbcm_pkg::MAX_WIDTH);
        h = eff_dim(cfg_h, bbcm_pkg::MAX_HEIGHT);
        early_ok = (w == done_w && h == done_h);   // store already holds this geometry
        finished = 1'b0;
        for (i = 0; i < w * h; i++) begin
            if (early_ok && $urandom_range(0, 9) == 0)
                send_word(make_word(1'b1, extreme), wrapped);
            send_word(make_word(1'b0, extreme), wrapped);
            if (wrapped) finished = 1'b1;
        end
        while (!finished) begin
            send_word(make_word($urandom_range(0, 7) != 0, extreme), wrapped);
            finished = wrapped;
        end
        if ($urandom_range(0, 3) == 0)
            send_word(make_word(1'b1, extreme), wrapped);
        done_w = w;
        done_h = h;
    endtask

    initial begin
        int unsigned i, sel;
        bit wrapped;
        logic [3:0] r;
        logic [12:0] w, h;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // oversize width, abandoned part-way; the next smaller frame restarts positions
        program_block(4'd1, 13'd8191, 13'd1, 1'b1);
        for (i = 0; i < 20; i++) send_word(make_word(1'b0, 1'b0), wrapped);
        // zero sizes: single pixel passes through
        program_block(4'd0, 13'd0, 13'd0, 1'b1);
        run_frame(1'b1);
        // too narrow for the radius: skipped results; 8-bit masking
        program_block(4'd1, 13'd3, 13'd2, 1'b0);
        run_frame(1'b1);
        // full-scale 16-bit samples, clipped edges
        program_block(4'd1, 13'd4, 13'd3, 1'b1);
        run_frame(1'b1);
        // same geometry again: early flushes allowed
        program_block(4'd2, 13'd4, 13'd3, 1'b0);
        run_frame(1'b1);

        while (words_sent < ITEM_TARGET) begin
            sel = $urandom_range(0, 99);
            if (sel < 8) begin
                r = 4'd15;
                w = 13'($urandom_range(32, 36));
                h = 13'($urandom_range(1, 2));
            end else if (sel < 14) begin
                r = 4'd0;
                w = 13'($urandom_range(1, 3));
                h = 13'($urandom_range(1, 6));
            end else begin
                r = 4'($urandom_range(0, sel < 70 ? 2 : 5));
                w = 13'($urandom_range(4, 24));
                h = 13'($urandom_range(1, 8));
            end
            // repeat the last geometry now and then so early flushes happen
            if ($urandom_range(0, 3) == 0 && done_w >= 4 && done_w <= 24) begin
                w = 13'(done_w);
                h = 13'(done_h);
            end
            program_block(r, w, h, 1'($urandom_range(0, 1)));
            calm = ($urandom_range(0, 2) == 0);
            if (!hold_done && words_sent >= HOLD_AT) begin
                hold_req = 1'b1;
                hold_done = 1'b1;
            end
            if (words_sent >= QUIET_AFTER) quiet = 1'b1;
            run_frame($urandom_range(0, 7) == 0);
        end

        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: sim.f
design/bbcm_pkg.sv
design/bbcm_div.sv
design/bbcm_store.sv
design/box_blur_clipped_mean.sv
tb/blur_checker.sv
tb/testbench.sv
